// ===== rtl/ttl_result_cache_table_unit_assert.svh =====
// Assertion macros for the result cache table.
`ifndef TTL_RESULT_CACHE_TABLE_UNIT_ASSERT_SVH
`define TTL_RESULT_CACHE_TABLE_UNIT_ASSERT_SVH

// Implication that is checked outside reset.
`define TTLC_ASSERT_IMP(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("ttlc assertion failed");

// Next-cycle implication that is checked outside reset.
`define TTLC_ASSERT_NXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("ttlc assertion failed");

`endif

// ===== rtl/ttlc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttlc_pkg: shared types and codes of the result cache table
// Status codes, cell word type and cell command struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttlc_pkg;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_HIT     = 3'd1;
    localparam logic [2:0] ST_MISS    = 3'd2;
    localparam logic [2:0] ST_EXPIRED = 3'd3;
    localparam logic [2:0] ST_REJECT  = 3'd4;

    localparam logic [1:0] FN_PUT   = 2'd0;
    localparam logic [1:0] FN_GET   = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;
    localparam logic [1:0] FN_STATS = 2'd3;

    // Byte addresses of the configuration registers.
    localparam logic [2:0] REG_BUDGET = 3'd0;
    localparam logic [2:0] REG_TTL    = 3'd4;

    localparam logic [31:0] BUDGET_RESET = 32'd67108864;
    localparam logic [31:0] TTL_RESET    = 32'd300;

    // Contents of one slot.
    typedef struct packed {
        logic [31:0] key;
        logic [15:0] tag;
        logic [31:0] size;
        logic [31:0] stamp;
        logic        valid;
    } entry_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic shift;    // cells at or above the victim take their upper neighbor
        logic write;    // the selected cell loads the new word
        logic clr_valid; // the selected cell drops its valid flag
    } cell_cmd_t;

endpackage

// ===== rtl/ttlc_cell.sv =====
// ----------------------------------------------------------------------------
// ttlc_cell: one slot of the cache table
// Holds one entry and can load the entry of its upper neighbor or a new word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttlc_cell (
    input  logic               aclk,
    input  ttlc_pkg::cell_cmd_t cmd,
    input  logic               sel,
    input  logic               above_victim,
    input  ttlc_pkg::entry_t   upper,
    input  ttlc_pkg::entry_t   wr_word,
    output ttlc_pkg::entry_t   word
);

    ttlc_pkg::entry_t word_reg;
    ttlc_pkg::entry_t word_next;

    // Select among hold, shift from neighbor, write and invalidate.
    always_comb begin
        word_next = word_reg;
        if (cmd.shift && above_victim) begin
            word_next = upper;
        end else if (cmd.write && sel) begin
            word_next = wr_word;
        end else if (cmd.clr_valid && sel) begin
            word_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== rtl/ttl_result_cache_table_unit.sv =====
// ----------------------------------------------------------------------------
// ttl_result_cache_table_unit: keyed result cache with oldest-first eviction
// A row of slot cells walked by a sequencer for lookup, oldest search and shift.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// s_axis  | in        | tdata: query_key, result_tag, result_size, now_seconds; tuser: func
// m_axis  | out       | tdata: found_tag, hit, miss, eviction totals; tuser: status
// apb     | in/out    | memory_budget at 0x0, time_to_live at 0x4
//
// The key scan takes one slot per cycle. A get miss goes from the scan to a decision, a put
// of a new key from the scan through a decision and an append; clear and statistics
// skip the scan. Each eviction adds an oldest search over the filled slots, a shift and
// one more decision.
// Reset clears counters, fill count and byte total; slot contents stay stale.
// A new item is taken only after the previous result has been transferred.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttl_result_cache_table_unit #(
    parameter int ENTRIES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // query_key, result_tag, result_size, now_seconds
    input  logic [1:0]   s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // found_tag, hit_total, miss_total, eviction_total
    output logic [2:0]   m_axis_tuser,  // status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOOK   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_SEARCH = 7'b0001000,
        S_SHIFT  = 7'b0010000,
        S_APPEND = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [31:0] budget_reg, ttl_reg;
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= ttlc_pkg::BUDGET_RESET;
            ttl_reg    <= ttlc_pkg::TTL_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr == ttlc_pkg::REG_BUDGET) budget_reg <= pwdata;
            else if (paddr == ttlc_pkg::REG_TTL) ttl_reg <= pwdata;
        end
    end
    assign prdata = (paddr == ttlc_pkg::REG_TTL) ? ttl_reg : budget_reg;

    // Latched request.
    logic [1:0]  fn_reg;
    logic [31:0] key_reg, size_reg, now_reg;
    logic [15:0] tag_reg;

    logic [CW-1:0] count_reg;
    logic [31:0]   bytes_reg, hits_reg, miss_reg, evict_reg;
    logic [IW-1:0] idx_reg, victim_reg;
    logic          found_reg;
    logic [IW-1:0] found_idx_reg;
    logic [2:0]    status_reg;
    logic [15:0]   otag_reg;
    logic          done_reg;

    // Slot row.
    ttlc_pkg::entry_t  words [ENTRIES];
    ttlc_pkg::entry_t  wr_word;
    ttlc_pkg::cell_cmd_t cmd;
    logic [IW-1:0]     sel_idx;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ttlc_pkg::entry_t up;
        if (g == ENTRIES - 1) begin : g_top
            assign up = words[g];
        end else begin : g_mid
            assign up = words[g+1];
        end
        ttlc_cell u_cell (
            .aclk         (aclk),
            .cmd          (cmd),
            .sel          (sel_idx == IW'(g)),
            .above_victim (IW'(g) >= victim_reg),
            .upper        (up),
            .wr_word      (wr_word),
            .word         (words[g])
        );
    end

    ttlc_pkg::entry_t cur;
    assign cur = words[idx_reg];

    logic [31:0] age;
    assign age = now_reg - cur.stamp;
    logic [32:0] need;
    assign need = {1'b0, bytes_reg} + {1'b0, size_reg};
    logic [IW-1:0] last_idx;
    assign last_idx = IW'(count_reg - CW'(1));

    assign s_axis_tready = (state_reg == S_IDLE) && !done_reg;
    assign m_axis_tvalid = done_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {evict_reg, miss_reg, hits_reg, otag_reg};

    always_comb begin
        wr_word.key   = key_reg;
        wr_word.tag   = tag_reg;
        wr_word.size  = size_reg;
        wr_word.stamp = now_reg;
        wr_word.valid = 1'b1;
    end

    // Commands to the slot row for the current state.
    always_comb begin
        cmd = '0;
        sel_idx = found_reg ? found_idx_reg : IW'(count_reg);
        case (state_reg)
            S_SHIFT: cmd.shift = 1'b1;
            S_APPEND: cmd.write = 1'b1;
            S_LOOK: begin
                sel_idx = idx_reg;
                if (count_reg != '0 && cur.key == key_reg && fn_reg == ttlc_pkg::FN_GET
                    && age > ttl_reg) begin
                    cmd.clr_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            bytes_reg <= '0;
            hits_reg  <= '0;
            miss_reg  <= '0;
            evict_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            if (done_reg && m_axis_tready) done_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        fn_reg    <= s_axis_tuser;
                        key_reg   <= s_axis_tdata[31:0];
                        tag_reg   <= s_axis_tdata[47:32];
                        size_reg  <= s_axis_tdata[79:48];
                        now_reg   <= s_axis_tdata[111:80];
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        otag_reg  <= '0;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    // Scan one slot per cycle for the key; clear and statistics go straight to the output.
                    if (fn_reg == ttlc_pkg::FN_CLEAR) begin
                        count_reg <= '0;
                        bytes_reg <= '0;
                        status_reg <= ttlc_pkg::ST_DONE;
                        state_reg <= S_OUT;
                    end else if (fn_reg == ttlc_pkg::FN_STATS) begin
                        status_reg <= ttlc_pkg::ST_DONE;
                        state_reg <= S_OUT;
                    end else if (count_reg == '0) begin
                        state_reg <= S_DECIDE;
                    end else if (cur.key == key_reg && fn_reg == ttlc_pkg::FN_PUT) begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= idx_reg;
                        bytes_reg     <= bytes_reg - cur.size + size_reg;
                        status_reg    <= ttlc_pkg::ST_DONE;
                        state_reg     <= S_APPEND;
                    end else if (cur.key == key_reg && age > ttl_reg) begin
                        miss_reg   <= miss_reg + 32'd1;
                        status_reg <= ttlc_pkg::ST_EXPIRED;
                        state_reg  <= S_OUT;
                    end else if (cur.key == key_reg && cur.valid) begin
                        hits_reg   <= hits_reg + 32'd1;
                        otag_reg   <= cur.tag;
                        status_reg <= ttlc_pkg::ST_HIT;
                        state_reg  <= S_OUT;
                    end else if (idx_reg == last_idx) begin
                        state_reg <= S_DECIDE;
                    end else begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                S_DECIDE: begin
                    // Miss on get, or decide whether a put is rejected or needs an eviction.
                    if (fn_reg == ttlc_pkg::FN_GET) begin
                        miss_reg   <= miss_reg + 32'd1;
                        status_reg <= ttlc_pkg::ST_MISS;
                        state_reg  <= S_OUT;
                    end else if (size_reg > budget_reg) begin
                        status_reg <= ttlc_pkg::ST_REJECT;
                        state_reg  <= S_OUT;
                    end else if (count_reg != '0 &&
                                 (count_reg >= FULL || need > {1'b0, budget_reg})) begin
                        idx_reg    <= '0;
                        victim_reg <= '0;
                        state_reg  <= S_SEARCH;
                    end else begin
                        status_reg <= ttlc_pkg::ST_DONE;
                        state_reg  <= S_APPEND;
                    end
                end
                S_SEARCH: begin
                    // Walk slots for the lowest timestamp; the lowest slot index wins ties.
                    if (cur.stamp < words[victim_reg].stamp) victim_reg <= idx_reg;
                    if (idx_reg == last_idx) begin
                        state_reg <= S_SHIFT;
                    end else begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                S_SHIFT: begin
                    bytes_reg <= bytes_reg - words[victim_reg].size;
                    count_reg <= count_reg - CW'(1);
                    evict_reg <= evict_reg + 32'd1;
                    state_reg <= S_DECIDE;
                end
                S_APPEND: begin
                    if (!found_reg) begin
                        count_reg <= count_reg + CW'(1);
                        bytes_reg <= bytes_reg + size_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!done_reg) begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `include "ttl_result_cache_table_unit_assert.svh"

    `TTLC_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= FULL)
    `TTLC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TTLC_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_axis_tready)

endmodule
